/* hw/rtl/pic_pkg.sv */
package pic_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int FRAC_BITS   = 8;
  localparam int INT_BITS    = 17;
  localparam int TEN_W       = 10;
  localparam int THR_W       = 16;
  localparam int CV_W        = 18;
  localparam int DUTY_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int INTEG_W     = INT_BITS + FRAC_BITS;
  // dividend width: sample * tenths, shifted up by the fraction bits
  localparam int NUM_W       = SAMPLE_BITS + TEN_W + FRAC_BITS;
  localparam int CNT_W       = $clog2(NUM_W);

  localparam logic [TEN_W-1:0] TENTHS_RESET = TEN_W'(10);
  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(30000);
  localparam logic [TEN_W-1:0] MAX_RESET    = TEN_W'(999);

  localparam logic [CFG_IDX_W-1:0] CFG_RESET_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MAX          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_TIME_MAX = 2'd2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   gain_up;
    logic                   gain_down;
    logic                   time_up;
    logic                   time_down;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [CV_W-1:0]   control_value;
    logic              integrator_cleared;
    logic [TEN_W-1:0]  gain_now;
    logic [TEN_W-1:0]  time_now;
  } out_t;

  typedef struct packed {
    logic capture;
    logic tune;
    logic mul;
    logic div_step;
    logic acc;
    logic sum;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

/* hw/rtl/pi_controller_with_tuning_buttons.sv */
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// in       | in_valid / in_stall | in_data: sample, gain/time up/down buttons
// out      | out_valid/out_stall | out_data: duty, control value, clear, tunings
// cfg      | cfg_write           | cfg_index, cfg_data (no read-back)
//
// One beat runs through these steps from accept to result:
// capture, tune, multiply, NUM_W restoring divide steps for the integral
// increment, accumulate (P/10 by reciprocal multiply), sum, finish.
// Synchronous active-high reset: tunings to 1.0, integrator to zero, registers
// to their defaults. A held result stalls only the finish step; the next beat
// is taken as soon as the previous one is in the output register.
module pi_controller_with_tuning_buttons (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pic_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pic_pkg::out_t                  out_data
);

  pic_pkg::cmd_t    cmd;
  pic_pkg::status_t st;

  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  pic_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/pic_ctrl.sv */
module pic_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pic_pkg::status_t st,
  output pic_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TUNE = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_ACC  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_TUNE;
        end
      end
      S_TUNE: begin
        cmd.tune   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.finish) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_TUNE))
    else $error("accepted beat did not start a computation");

  a_div_complete: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> $past(st.div_done))
    else $error("accumulate entered before division finished");
`endif

endmodule

/* hw/rtl/pic_dpath.sv */
module pic_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pic_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  pic_pkg::in_t                      in_data,
  input  pic_pkg::cmd_t                     cmd,
  output pic_pkg::status_t                  st,
  output pic_pkg::out_t                     out_data
);

  localparam int TW   = pic_pkg::TEN_W;
  localparam int NW   = pic_pkg::NUM_W;
  localparam int FB   = pic_pkg::FRAC_BITS;
  localparam int SB   = pic_pkg::SAMPLE_BITS;
  localparam int IW   = pic_pkg::INTEG_W;
  localparam int CW   = pic_pkg::CV_W;
  localparam int DW   = pic_pkg::DUTY_W;
  localparam int PB_W = SB + 4;
  localparam int HI_W = NW - FB + 1;
  localparam int M1_W = CW - DW + 1;
  localparam int RW   = 29;
  localparam int RSH  = 32;

  localparam logic [NW:0]     INTEG_MAX_X = (NW+1)'({IW{1'b1}});
  localparam logic [HI_W-1:0] CV_MAX_X    = HI_W'({CW{1'b1}});
  localparam logic [DW:0]     MOD_255     = (DW+1)'(255);
  // x / 10 = (x * ceil(2^32 / 10)) >> 32, exact for x below 2^28
  localparam logic [RW-1:0]   RECIP_10    = RW'(429496730);

  // step a tuning value, then clamp to [1, vmax]
  function automatic logic [TW-1:0] tune(input logic [TW-1:0] v, input logic up,
                                         input logic down, input logic [TW-1:0] vmax);
    logic [TW:0] t;
    t = {1'b0, v} + {{TW{1'b0}}, up};
    if (down && t > (TW+1)'(1)) t = t - (TW+1)'(1);
    if (t > {1'b0, vmax}) t = {1'b0, vmax};
    if (t < (TW+1)'(1)) t = (TW+1)'(1);
    return t[TW-1:0];
  endfunction

  // one restoring division step: {remainder, dividend/quotient shift register}
  function automatic logic [TW+NW-1:0] dstep(input logic [TW-1:0] rem,
                                             input logic [NW-1:0] num,
                                             input logic [TW-1:0] d);
    logic [TW:0]   trial;
    logic          ge;
    logic [TW-1:0] r;
    trial = {rem, num[NW-1]};
    ge    = trial >= {1'b0, d};
    r     = ge ? TW'(trial - {1'b0, d}) : trial[TW-1:0];
    return {r, num[NW-2:0], ge};
  endfunction

  logic [pic_pkg::THR_W-1:0] thr;
  logic [TW-1:0]             gain_max, time_max;
  pic_pkg::in_t              cap;
  logic [TW-1:0]             gain, ti;
  logic [NW-1:0]             num_p, num_i;
  logic [TW-1:0]             rem_i;
  logic [pic_pkg::CNT_W-1:0] cnt;
  logic [IW-1:0]             integ;
  logic [CW-1:0]             cv;

  logic [SB+TW-1:0]  prod_p;
  logic [PB_W-1:0]   prod_i;
  logic [NW+RW-1:0]  p_prod;
  logic [NW:0]       acc_w, sum_w;
  logic [HI_W-1:0]   cv_hi;
  logic [M1_W-1:0]   m1;
  logic [DW:0]       m2;
  logic [DW-1:0]     duty;
  logic              clr;

  assign prod_p = (SB+TW)'(cap.sample) * (SB+TW)'(gain);
  assign prod_i = PB_W'(cap.sample) * PB_W'(10);
  assign p_prod = (NW+RW)'(num_p) * (NW+RW)'(RECIP_10);
  assign acc_w  = (NW+1)'(integ) + (NW+1)'(num_i);
  assign sum_w  = (NW+1)'(num_p) + (NW+1)'(integ);
  assign cv_hi  = sum_w[NW:FB];

  // mod 255: fold the bits above the low byte into the low byte twice, then one correction
  assign m1   = M1_W'(cv[CW-1:DW]) + M1_W'(cv[DW-1:0]);
  assign m2   = (DW+1)'(m1[M1_W-1:DW]) + (DW+1)'(m1[DW-1:0]);
  assign duty = (m2 >= MOD_255) ? DW'(m2 - MOD_255) : m2[DW-1:0];
  assign clr  = cv > CW'(thr);

  assign st.div_done = (cnt == pic_pkg::CNT_W'(NW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= pic_pkg::THR_RESET;
      gain_max <= pic_pkg::MAX_RESET;
      time_max <= pic_pkg::MAX_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pic_pkg::CFG_RESET_THRESHOLD:   thr      <= cfg_data[pic_pkg::THR_W-1:0];
        pic_pkg::CFG_GAIN_MAX:          gain_max <= cfg_data[TW-1:0];
        pic_pkg::CFG_INTEGRAL_TIME_MAX: time_max <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= pic_pkg::TENTHS_RESET;
      ti    <= pic_pkg::TENTHS_RESET;
      integ <= '0;
      cnt   <= '0;
    end else begin
      if (cmd.tune) begin
        gain <= tune(gain, cap.gain_up, cap.gain_down, gain_max);
        ti   <= tune(ti, cap.time_up, cap.time_down, time_max);
      end
      if (cmd.mul) cnt <= '0;
      else if (cmd.div_step) cnt <= cnt + 1'b1;
      if (cmd.acc) integ <= (acc_w > INTEG_MAX_X) ? INTEG_MAX_X[IW-1:0] : acc_w[IW-1:0];
      else if (cmd.finish && clr) integ <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cap <= in_data;
    if (cmd.mul) begin
      num_i <= {{(NW-PB_W-FB){1'b0}}, prod_i, {FB{1'b0}}};
      rem_i <= '0;
    end else if (cmd.div_step) begin
      {rem_i, num_i} <= dstep(rem_i, num_i, ti);
    end
    // proportional dividend is replaced by its quotient in the accumulate step
    if (cmd.mul) num_p <= {prod_p, {FB{1'b0}}};
    else if (cmd.acc) num_p <= NW'(p_prod[NW+RW-1:RSH]);
    if (cmd.sum) cv <= (cv_hi > CV_MAX_X) ? CV_MAX_X[CW-1:0] : cv_hi[CW-1:0];
    if (cmd.finish) begin
      out_data.duty               <= duty;
      out_data.control_value      <= cv;
      out_data.integrator_cleared <= clr;
      out_data.gain_now           <= gain;
      out_data.time_now           <= ti;
    end
  end

endmodule
